@@ src/keyword_prefix_matcher_core_macros.svh @@
// Assertion macros used by the keyword prefix matcher back end.
`ifndef KEYWORD_PREFIX_MATCHER_CORE_MACROS_SVH
`define KEYWORD_PREFIX_MATCHER_CORE_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define KPM_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("keyword matcher assertion failed");

// Checks that a condition implies another in the same cycle.
`define KPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyword matcher assertion failed");

// Checks that a condition implies another in the following cycle.
`define KPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyword matcher assertion failed");

`endif

@@ src/kpm_pkg.sv @@
// Shared types, constants and functions of the keyword prefix matcher.
`default_nettype none

package kpm_pkg;

  localparam int COUNT_W     = 5;
  localparam int WINDOW_BITS = 128;
  localparam int RESULT_IDX_W = 5;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic                   is_check;
    logic [WINDOW_BITS-1:0] bytes;
    logic [COUNT_W-1:0]     len;
  } cmd_t;

  // Folds ASCII upper-case letters to lower case when enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ci);
    logic [7:0] r;
    r = c;
    if (ci && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/kpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/kpm_front.sv @@
// Front end: classifies input beats and holds them in a two-entry queue.
`default_nettype none

module kpm_front #(
  parameter int MAX_KEYWORD_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          action,
  input  logic [63:0]   chars_low,
  input  logic [63:0]   chars_high,
  input  logic [4:0]    char_count,
  output logic          cmd_valid,
  output kpm_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import kpm_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       in_cmd;
  logic       do_push;

  always_comb begin
    in_cmd.is_check = (action == ACT_CHECK);
    in_cmd.bytes    = {chars_high, chars_low};
    // Counts beyond the longest keyword saturate.
    if (char_count > COUNT_W'(MAX_KEYWORD_BYTES)) begin
      in_cmd.len = COUNT_W'(MAX_KEYWORD_BYTES);
    end else begin
      in_cmd.len = char_count;
    end
  end

  assign full      = (fill == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, cmd_take};
    end
  end

endmodule

`default_nettype wire

@@ src/kpm_back.sv @@
// Back end: keyword table, one-entry-per-cycle scan and result register.
`default_nettype none
`include "keyword_prefix_matcher_core_macros.svh"

module kpm_back #(
  parameter int TABLE_DEPTH       = 32,
  parameter int MAX_KEYWORD_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          case_insensitive,
  input  logic          cmd_valid,
  input  kpm_pkg::cmd_t cmd,
  output logic          cmd_take,
  input  logic          pop,
  output logic          empty,
  output logic          matched,
  output logic [4:0]    match_index,
  output logic [4:0]    match_length,
  output logic          add_rejected
);
  import kpm_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KB = MAX_KEYWORD_BYTES * 8;
  localparam int RW = KB + COUNT_W;

  back_state_t          state, state_next;
  logic [CW-1:0]        keyword_count, keyword_count_next;
  logic [IW-1:0]        cmp_idx, cmp_idx_next;
  cmd_t                 cur;
  logic                 out_valid, out_valid_next;
  logic                 matched_next;
  logic [RESULT_IDX_W-1:0] match_index_next;
  logic [COUNT_W-1:0]   match_length_next;
  logic                 add_rejected_next;

  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;
  logic [COUNT_W-1:0]   kw_len;
  logic [KB-1:0]        kw_bytes;
  logic                 all_eq;
  logic                 hit;
  logic                 last;

  kpm_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (keyword_count[IW-1:0]),
    .wdata ({cmd.len, cmd.bytes[KB-1:0]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry zero is read while idle so that a scan finds it ready on entry.
  assign ram_raddr = (state == ST_SCAN) ? (cmp_idx + IW'(1)) : '0;
  assign kw_len    = ram_rdata[RW-1:KB];
  assign kw_bytes  = ram_rdata[KB-1:0];

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < MAX_KEYWORD_BYTES; i++) begin
      if ((COUNT_W'(i) < kw_len) &&
          (fold_byte(kw_bytes[8*i +: 8], case_insensitive) !=
           fold_byte(cur.bytes[8*i +: 8], case_insensitive))) begin
        all_eq = 1'b0;
      end
    end
    hit  = (kw_len <= cur.len) && all_eq;
    last = ((CW'(cmp_idx) + CW'(1)) == keyword_count);
  end

  always_comb begin
    state_next         = state;
    keyword_count_next = keyword_count;
    cmp_idx_next       = cmp_idx;
    out_valid_next     = out_valid && !pop;
    matched_next       = matched;
    match_index_next   = match_index;
    match_length_next  = match_length;
    add_rejected_next  = add_rejected;
    cmd_take           = 1'b0;
    ram_we             = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && (!out_valid || pop)) begin
          cmd_take          = 1'b1;
          matched_next      = 1'b0;
          match_index_next  = '0;
          match_length_next = '0;
          add_rejected_next = 1'b0;
          if (!cmd.is_check) begin
            out_valid_next = 1'b1;
            if ((cmd.len == '0) || (keyword_count == CW'(TABLE_DEPTH))) begin
              add_rejected_next = 1'b1;
            end else begin
              ram_we             = 1'b1;
              keyword_count_next = keyword_count + CW'(1);
            end
          end else if (keyword_count == '0) begin
            out_valid_next = 1'b1;
          end else begin
            state_next   = ST_SCAN;
            cmp_idx_next = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          out_valid_next    = 1'b1;
          matched_next      = 1'b1;
          match_index_next  = RESULT_IDX_W'(cmp_idx);
          match_length_next = kw_len;
          state_next        = ST_IDLE;
        end else if (last) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmp_idx_next = cmp_idx + IW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      keyword_count <= '0;
      cmp_idx       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      keyword_count <= keyword_count_next;
      cmp_idx       <= cmp_idx_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
    matched      <= matched_next;
    match_index  <= match_index_next;
    match_length <= match_length_next;
    add_rejected <= add_rejected_next;
  end

  assign empty = !out_valid;

  `KPM_ASSERT(a_count_bound, keyword_count <= CW'(TABLE_DEPTH))
  `KPM_ASSERT_IMP(a_scan_result_free, state == ST_SCAN, !out_valid)
  `KPM_ASSERT_IMP(a_scan_in_table, state == ST_SCAN, CW'(cmp_idx) < keyword_count)
  `KPM_ASSERT_NEXT(a_add_grows, ram_we, keyword_count == $past(keyword_count) + CW'(1))

endmodule

`default_nettype wire

@@ src/keyword_prefix_matcher_core.sv @@
// Top level of the keyword prefix matcher: configuration port, front and back.
//
//   channel   direction  handshake            payload
//   items     in         push / full          action, chars_low, chars_high, char_count
//   results   out        pop / empty          matched, match_index, match_length, add_rejected
//   config    in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// An add is handled in the back end's idle state; a check scans the stored keywords
// in insertion order through the single table read port and stops at the first hit
// or after the last one. The result appears in the cycle after the back end finishes.
// Reset is synchronous on rst; the table needs no clearing pass.
// A two-entry queue in front keeps accepting beats while a result waits, until it is full.
`default_nettype none

module keyword_prefix_matcher_core #(
  parameter int TABLE_DEPTH       = 32,
  parameter int MAX_KEYWORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [63:0] chars_low,
  input  logic [63:0] chars_high,
  input  logic [4:0]  char_count,
  input  logic        pop,
  output logic        empty,
  output logic        matched,
  output logic [4:0]  match_index,
  output logic [4:0]  match_length,
  output logic        add_rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kpm_pkg::*;

  localparam logic REG_CASE_INSENSITIVE = 1'b0;

  logic case_insensitive;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CASE_INSENSITIVE) ? {31'b0, case_insensitive} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_insensitive <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_CASE_INSENSITIVE)) begin
      case_insensitive <= pwdata[0];
    end
  end

  kpm_front #(
    .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .chars_low  (chars_low),
    .chars_high (chars_high),
    .char_count (char_count),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  kpm_back #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .case_insensitive (case_insensitive),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take),
    .pop              (pop),
    .empty            (empty),
    .matched          (matched),
    .match_index      (match_index),
    .match_length     (match_length),
    .add_rejected     (add_rejected)
  );

endmodule

`default_nettype wire

@@ test/keyword_match_checker.sv @@
// Checker for the keyword prefix matcher: keeps its own keyword table, predicts every result beat and compares it.
module keyword_match_checker #(
  parameter logic [2:0] CASE_REG_ADDR     = 3'd0,
  parameter int         TABLE_DEPTH       = 32,
  parameter int         MAX_KEYWORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        action,
  input  logic [63:0] chars_low,
  input  logic [63:0] chars_high,
  input  logic [4:0]  char_count,
  input  logic        pop,
  input  logic        empty,
  input  logic        matched,
  input  logic [4:0]  match_index,
  input  logic [4:0]  match_length,
  input  logic        add_rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          failures,
  output int          outstanding,
  output int          results_seen,
  output int          hits,
  output int          rejects
);
  import kpm_pkg::*;

  typedef struct packed {
    logic       matched;
    logic [4:0] index;
    logic [4:0] length;
    logic       rejected;
  } answer_t;

  logic [127:0] stored_words [TABLE_DEPTH];
  int unsigned  stored_lens [TABLE_DEPTH];
  int unsigned  stored_count;
  logic         fold_case;
  answer_t      answers_due [$];

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    if (fold_case && b >= 8'h41 && b <= 8'h5A) begin
      return b | 8'h20;
    end
    return b;
  endfunction

  // Applies one input beat to the local table and returns the answer it should produce.
  function automatic answer_t predict_answer(input logic act, input logic [127:0] text,
                                             input logic [4:0] raw_count);
    answer_t     ans;
    int unsigned n;
    int unsigned len;
    bit          same;
    ans = '0;
    n = (raw_count > MAX_KEYWORD_BYTES) ? MAX_KEYWORD_BYTES : raw_count;
    if (act == ACT_ADD) begin
      if (n == 0 || stored_count >= TABLE_DEPTH) begin
        ans.rejected = 1'b1;
      end else begin
        stored_words[stored_count] = text;
        stored_lens[stored_count]  = n;
        stored_count++;
      end
      return ans;
    end
    // Insertion order decides: the first keyword that fits wins.
    for (int z = 0; z < stored_count; z++) begin
      len = stored_lens[z];
      if (len <= n) begin
        same = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (to_lower(text[8*i +: 8]) != to_lower(stored_words[z][8*i +: 8])) begin
            same = 1'b0;
          end
        end
        if (same) begin
          ans.matched = 1'b1;
          ans.index   = z[4:0];
          ans.length  = len[4:0];
          return ans;
        end
      end
    end
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      answers_due.delete();
      stored_count = 0;
      fold_case    = 1'b0;
      failures     = 0;
      outstanding  = 0;
      results_seen = 0;
      hits         = 0;
      rejects      = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == CASE_REG_ADDR) begin
            fold_case = pwdata[0];
          end
        end else if (paddr == CASE_REG_ADDR && prdata !== {31'b0, fold_case}) begin
          failures++;
          $display("%0t: register read mismatch: expected %0h, got %0h",
                   $time, {31'b0, fold_case}, prdata);
        end
      end
      // Result beats are matched before this edge's input beat is predicted.
      if (pop && !empty) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          failures++;
          $display("%0t: result beat with nothing expected: expected none, got %0b/%0d/%0d/%0b",
                   $time, matched, match_index, match_length, add_rejected);
        end else begin
          want = answers_due.pop_front();
          check_field("matched", {4'b0, want.matched}, {4'b0, matched});
          check_field("match_index", want.index, match_index);
          check_field("match_length", want.length, match_length);
          check_field("add_rejected", {4'b0, want.rejected}, {4'b0, add_rejected});
        end
        if (matched === 1'b1) hits++;
        if (add_rejected === 1'b1) rejects++;
      end
      if (push && !full) begin
        answers_due.push_back(predict_answer(action, {chars_high, chars_low}, char_count));
      end
      outstanding = answers_due.size();
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the keyword prefix matcher testbench: clock, reset, stimulus, result draining and verdict.
module testbench;
  import kpm_pkg::*;

  localparam logic [2:0] ADDR_CASE_INSENSITIVE = 3'd0;
  localparam int         SETTLE_CYCLES         = 40;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        action;
  logic [63:0] chars_low;
  logic [63:0] chars_high;
  logic [4:0]  char_count;
  logic        pop;
  logic        empty;
  logic        matched;
  logic [4:0]  match_index;
  logic [4:0]  match_length;
  logic        add_rejected;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int failures;
  int outstanding;
  int results_seen;
  int hits;
  int rejects;
  int items_sent;
  bit calm;

  // Non-empty keywords sent so far, used to build windows that start with a known keyword.
  logic [127:0] pool_words [$];
  int           pool_lens [$];

  keyword_prefix_matcher_core uut (.*);

  keyword_match_checker #(.CASE_REG_ADDR(ADDR_CASE_INSENSITIVE)) scoreboard (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [127:0] rand_window();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Mostly a four-letter alphabet so that keywords overlap, now and then the case-folding edges.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, ($urandom_range(0, 2) == 0) ? 11 : 3))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h41;
      3:       return 8'h42;
      4:       return 8'h40;
      5:       return 8'h5B;
      6:       return 8'h60;
      7:       return 8'h7B;
      8:       return 8'h5A;
      9:       return 8'h7A;
      10:      return 8'hC1;
      default: return 8'hE1;
    endcase
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1)) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  task automatic send_item(input logic act, input logic [127:0] text, input logic [4:0] cnt);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action     <= act;
    chars_low  <= text[63:0];
    chars_high <= text[127:64];
    char_count <= cnt;
    push       <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic add_keyword(input logic [127:0] text, input logic [4:0] cnt);
    send_item(ACT_ADD, text, cnt);
    if (cnt != 0) begin
      pool_words.push_back(text);
      pool_lens.push_back((cnt > 16) ? 16 : cnt);
    end
  endtask

  task automatic check_window(input logic [127:0] text, input logic [4:0] cnt);
    send_item(ACT_CHECK, text, cnt);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_CASE_INSENSITIVE;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write then read back the folding bit, only with nothing in flight.
  task automatic set_case_folding(input logic enable);
    wait_idle();
    apb_access(1'b1, {31'b0, enable});
    apb_access(1'b0, '0);
  endtask

  task automatic random_keyword(output logic [127:0] text, output logic [4:0] len);
    text = rand_window();
    len  = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4));
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < len; i++) text[8*i +: 8] = pick_char();
    end
  endtask

  task automatic random_item();
    logic [127:0] text;
    logic [127:0] word;
    logic [4:0]   len;
    logic [4:0]   cnt;
    int           pick;
    int           r;
    bit           flip;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      random_keyword(text, len);
      case ($urandom_range(0, 9))
        0:       cnt = '0;
        1:       cnt = 5'($urandom_range(17, 31));
        default: cnt = len;
      endcase
      add_keyword(text, cnt);
    end else if (r < 70 && pool_words.size() > 0) begin
      // A window that starts with a known keyword, possibly with its case changed or one byte spoilt.
      pick = $urandom_range(0, pool_words.size() - 1);
      word = pool_words[pick];
      len  = 5'(pool_lens[pick]);
      flip = ($urandom_range(0, 2) == 0);
      text = rand_window();
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 1)) text[8*i +: 8] = pick_char();
      end
      for (int i = 0; i < len; i++) begin
        text[8*i +: 8] = flip ? flip_case(word[8*i +: 8]) : word[8*i +: 8];
      end
      if ($urandom_range(0, 6) == 0) text[8*$urandom_range(0, len - 1) +: 8] = pick_char();
      case ($urandom_range(0, 19))
        0, 1:    cnt = 5'($urandom_range(0, len - 1));
        2:       cnt = 5'($urandom_range(17, 31));
        default: cnt = 5'($urandom_range(len, 16));
      endcase
      check_window(text, cnt);
    end else if (r < 85) begin
      text = rand_window();
      for (int i = 0; i < 16; i++) text[8*i +: 8] = pick_char();
      check_window(text, 5'($urandom_range(0, 16)));
    end else begin
      check_window(rand_window(), 5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    int gap;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    logic [127:0] text;
    int           phase_len [3];
    clk        = 1'b0;
    rst        = 1'b1;
    push       = 1'b0;
    action     = ACT_ADD;
    chars_low  = '0;
    chars_high = '0;
    char_count = '0;
    pop        = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    items_sent = 0;
    phase_len  = '{700, 600, 500};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_case_folding(1'b0);
    check_window(rand_window(), 16);
    add_keyword(rand_window(), 0);
    text = rand_window();
    text[7:0] = 8'h61;
    add_keyword(text, 1);
    add_keyword({128{1'b1}}, 31);
    text = rand_window();
    text[23:0] = {8'h5A, 8'h7B, 8'h60};
    add_keyword(text, 3);
    text = rand_window();
    text[15:0] = {8'h42, 8'hC1};
    add_keyword(text, 2);
    text = rand_window();
    text[7:0] = 8'h41;
    check_window(text, 1);
    text = rand_window();
    text[7:0] = 8'h61;
    check_window(text, 1);
    check_window({128{1'b1}}, 16);
    check_window({128{1'b1}}, 31);
    check_window({128{1'b1}}, 15);
    check_window(rand_window(), 0);
    text = rand_window();
    text[15:0] = {8'h62, 8'hE1};
    check_window(text, 2);
    check_window({{64{1'b1}}, 64'h0}, 16);

    set_case_folding(1'b1);
    text = rand_window();
    text[7:0] = 8'h41;
    check_window(text, 1);
    text[15:0] = {8'h62, 8'hE1};
    check_window(text, 2);
    text[15:0] = {8'h62, 8'hC1};
    check_window(text, 2);
    text[23:0] = {8'h7A, 8'h7B, 8'h40};
    check_window(text, 3);
    text[23:0] = {8'h7A, 8'h7B, 8'h60};
    check_window(text, 5);
    text[23:0] = {8'h5A, 8'h5B, 8'h60};
    check_window(text, 3);

    // Folding on, then off, then on again; the table fills up during the first phase.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase > 0) set_case_folding(phase == 2);
      for (int k = 0; k < phase_len[phase]; k++) begin
        if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        random_item();
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d input beats and %0d result beats: %0d matches, %0d rejected adds.",
             items_sent, results_seen, hits, rejects);
    $display("Case folding was switched off and on between phases, with the table filled to depth.");
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
